// File: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared constants and types for the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  // default sizes
  localparam int unsigned CAPACITY_DEF      = 16;
  localparam int unsigned PRIORITY_BITS_DEF = 16;
  localparam int unsigned TAG_BITS_DEF      = 32;

  // operation codes of a request
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic execute;  // apply the latched request and load the result register
  } spq_cmd_t;

endpackage

// File: design/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// request sequencing and result handshake for the sorted priority queue
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output spq_pkg::spq_cmd_t cmd_o
);
  import spq_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        exec_go;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign exec_go     = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  assign cmd_o.capture = in_valid_i && in_ready_o;
  assign cmd_o.execute = exec_go;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: design/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// sorted shift-register cells, request latch and result register
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int unsigned Capacity     = spq_pkg::CAPACITY_DEF,
  parameter int unsigned PriorityBits = spq_pkg::PRIORITY_BITS_DEF,
  parameter int unsigned TagBits      = spq_pkg::TAG_BITS_DEF,
  parameter int unsigned CountBits    = $clog2(Capacity + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  spq_pkg::spq_cmd_t       cmd_i,
  input  logic                    op_i,
  input  logic [PriorityBits-1:0] priority_req_i,
  input  logic [TagBits-1:0]      tag_i,
  output logic [TagBits-1:0]      removed_tag_o,
  output logic                    removed_valid_o,
  output logic                    overflow_o,
  output logic [PriorityBits-1:0] head_priority_o,
  output logic [TagBits-1:0]      head_tag_o,
  output logic                    is_empty_o,
  output logic [CountBits-1:0]    occupancy_o
);
  import spq_pkg::*;

  // latched request
  logic                    op_q;
  logic [PriorityBits-1:0] pri_q;
  logic [TagBits-1:0]      tag_q;

  // sorted cells, cell 0 is the head
  logic [PriorityBits-1:0] cell_pri_q [Capacity];
  logic [PriorityBits-1:0] cell_pri_d [Capacity];
  logic [TagBits-1:0]      cell_tag_q [Capacity];
  logic [TagBits-1:0]      cell_tag_d [Capacity];
  logic [CountBits-1:0]    count_q, count_d;

  // result register
  logic [TagBits-1:0]      res_rtag_q, res_rtag_d;
  logic                    res_rvalid_q, res_rvalid_d;
  logic                    res_ovf_q, res_ovf_d;
  logic [PriorityBits-1:0] res_hpri_q, res_hpri_d;
  logic [TagBits-1:0]      res_htag_q, res_htag_d;
  logic                    res_empty_q, res_empty_d;
  logic [CountBits-1:0]    res_count_q;

  logic [Capacity-1:0] below;  // live cell with priority strictly below the new one
  logic                full, empty, do_enq, do_deq;

  assign full   = (count_q == CountBits'(Capacity));
  assign empty  = (count_q == '0);
  assign do_enq = (op_q == OP_ENQUEUE) && !full;
  assign do_deq = (op_q == OP_DEQUEUE) && !empty;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    assign below[i] = (CountBits'(i) < count_q) && (cell_pri_q[i] < pri_q);

    always_comb begin
      cell_pri_d[i] = cell_pri_q[i];
      cell_tag_d[i] = cell_tag_q[i];
      if (do_enq && !below[i]) begin
        if (i == 0) begin
          cell_pri_d[i] = pri_q;
          cell_tag_d[i] = tag_q;
        end else if (below[(i == 0) ? 0 : i - 1]) begin
          cell_pri_d[i] = pri_q;
          cell_tag_d[i] = tag_q;
        end else begin
          cell_pri_d[i] = cell_pri_q[(i == 0) ? 0 : i - 1];
          cell_tag_d[i] = cell_tag_q[(i == 0) ? 0 : i - 1];
        end
      end else if (do_deq && (i < Capacity - 1)) begin
        cell_pri_d[i] = cell_pri_q[(i < Capacity - 1) ? i + 1 : i];
        cell_tag_d[i] = cell_tag_q[(i < Capacity - 1) ? i + 1 : i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.execute) begin
        cell_pri_q[i] <= cell_pri_d[i];
        cell_tag_q[i] <= cell_tag_d[i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_enq) begin
      count_d = count_q + CountBits'(1);
    end else if (do_deq) begin
      count_d = count_q - CountBits'(1);
    end
    res_rtag_d   = do_deq ? cell_tag_q[0] : '0;
    res_rvalid_d = do_deq;
    res_ovf_d    = (op_q == OP_ENQUEUE) && full;
    res_empty_d  = (count_d == '0);
    res_hpri_d   = res_empty_d ? '0 : cell_pri_d[0];
    res_htag_d   = res_empty_d ? '0 : cell_tag_d[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      pri_q <= priority_req_i;
      tag_q <= tag_i;
    end
    if (cmd_i.execute) begin
      res_rtag_q   <= res_rtag_d;
      res_rvalid_q <= res_rvalid_d;
      res_ovf_q    <= res_ovf_d;
      res_hpri_q   <= res_hpri_d;
      res_htag_q   <= res_htag_d;
      res_empty_q  <= res_empty_d;
      res_count_q  <= count_d;
    end
  end

  assign removed_tag_o   = res_rtag_q;
  assign removed_valid_o = res_rvalid_q;
  assign overflow_o      = res_ovf_q;
  assign head_priority_o = res_hpri_q;
  assign head_tag_o      = res_htag_q;
  assign is_empty_o      = res_empty_q;
  assign occupancy_o     = res_count_q;

endmodule

// File: design/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded minimum-first priority queue built as a sorted shift-register array
// ----------------------------------------------------------------------------
// A request either enqueues a (priority, tag) pair or dequeues the head entry.
// Entries sit in a row of cells sorted by ascending priority, cell 0 being the
// head; a new entry goes in front of every entry of equal priority, so ties are
// served newest first. Every request yields exactly one result that carries the
// removed tag (dequeue), an overflow flag (enqueue into a full queue, which is
// dropped) and the head entry, empty flag and occupancy after the request.
// Each request is first latched, then in an update step all cells compare
// against the new priority in parallel and shift in one step; the result then
// waits in an output register, so the next request is taken while the
// previous result is still pending. A request is held in the update cycle
// only while the output register is full and not being drained.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int unsigned CAPACITY      = spq_pkg::CAPACITY_DEF,
  parameter int unsigned PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int unsigned TAG_BITS      = spq_pkg::TAG_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              op_i,
  input  logic [PRIORITY_BITS-1:0]          priority_req_i,
  input  logic [TAG_BITS-1:0]               tag_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [TAG_BITS-1:0]               removed_tag_o,
  output logic                              removed_valid_o,
  output logic                              overflow_o,
  output logic [PRIORITY_BITS-1:0]          head_priority_o,
  output logic [TAG_BITS-1:0]               head_tag_o,
  output logic                              is_empty_o,
  output logic [$clog2(CAPACITY + 1)-1:0]   occupancy_o
);
  import spq_pkg::*;

  // command bundle from the sequencer to the cell array
  spq_cmd_t cmd;

  // sequencer: latch cycle, update cycle, output register handshake
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // sorted cells, entry count and result register
  spq_datapath #(
    .Capacity     (CAPACITY),
    .PriorityBits (PRIORITY_BITS),
    .TagBits      (TAG_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .op_i            (op_i),
    .priority_req_i  (priority_req_i),
    .tag_i           (tag_i),
    .removed_tag_o   (removed_tag_o),
    .removed_valid_o (removed_valid_o),
    .overflow_o      (overflow_o),
    .head_priority_o (head_priority_o),
    .head_tag_o      (head_tag_o),
    .is_empty_o      (is_empty_o),
    .occupancy_o     (occupancy_o)
  );

endmodule

// File: design/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks for the sorted priority queue
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int unsigned CAPACITY      = spq_pkg::CAPACITY_DEF,
  parameter int unsigned PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int unsigned TAG_BITS      = spq_pkg::TAG_BITS_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [TAG_BITS-1:0]             removed_tag_o,
  input logic                            removed_valid_o,
  input logic                            overflow_o,
  input logic [PRIORITY_BITS-1:0]        head_priority_o,
  input logic [TAG_BITS-1:0]             head_tag_o,
  input logic                            is_empty_o,
  input logic [$clog2(CAPACITY + 1)-1:0] occupancy_o
);

  localparam int unsigned OccBits = $clog2(CAPACITY + 1);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(removed_tag_o)
      && $stable(head_priority_o) && $stable(head_tag_o) && $stable(occupancy_o))
    else $error("result changed while stalled");

  // empty flag agrees with occupancy
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (occupancy_o == '0)))
    else $error("empty flag and occupancy disagree");

  // a dropped enqueue only happens on a full queue
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> (occupancy_o == OccBits'(CAPACITY))
      && !removed_valid_o)
    else $error("overflow without a full queue");

  // an empty queue shows a zero head
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> (head_priority_o == '0) && (head_tag_o == '0))
    else $error("empty queue with nonzero head");

endmodule

bind sorted_priority_queue spq_checker #(
  .CAPACITY      (CAPACITY),
  .PRIORITY_BITS (PRIORITY_BITS),
  .TAG_BITS      (TAG_BITS)
) u_spq_checker (.*);

// File: test/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// self-checking bench for the bounded minimum-first priority queue
// ----------------------------------------------------------------------------
// A scoreboard keeps its own sorted copy of the queue. Each accepted request is
// applied to that copy to predict the result, and each result leaving the
// block is checked field by field against the oldest prediction. A short
// directed list covers empty dequeue, extreme priorities and tags, and ties.
// Then random bursts that lean toward filling, draining or neither drive the
// queue through full (overflow) and empty many times, under three idling
// patterns on the two channels.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;

  localparam int unsigned CAP   = spq_pkg::CAPACITY_DEF;
  localparam int unsigned PRI_W = spq_pkg::PRIORITY_BITS_DEF;
  localparam int unsigned TAG_W = spq_pkg::TAG_BITS_DEF;
  localparam int unsigned OCC_W = $clog2(CAP + 1);

  // one result as seen on the output channel
  typedef struct packed {
    logic [TAG_W-1:0] removed_tag;
    logic             removed_valid;
    logic             overflow;
    logic [PRI_W-1:0] head_priority;
    logic [TAG_W-1:0] head_tag;
    logic             is_empty;
    logic [OCC_W-1:0] occupancy;
  } queue_result_t;

  // leaning of a random burst of requests
  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_kind_e;

  // --------------------------------------------------------------------------
  // scoreboard: sorted shadow of the queue plus the list of predicted results
  // --------------------------------------------------------------------------
  class queue_scoreboard;
    logic [PRI_W-1:0] slot_pri [CAP];
    logic [TAG_W-1:0] slot_tag [CAP];
    int unsigned      held;
    queue_result_t    predicted_q [$];
    int unsigned      mismatches;

    function new();
      held       = 0;
      mismatches = 0;
    endfunction

    // apply an accepted request to the shadow queue and predict its result
    function void note_request(logic op, logic [PRI_W-1:0] pri, logic [TAG_W-1:0] tg);
      queue_result_t r;
      int unsigned   pos;
      int unsigned   i;
      r = '0;
      if (op == spq_pkg::OP_ENQUEUE) begin
        if (held >= CAP) begin
          r.overflow = 1'b1;
        end else begin
          // new entry lands ahead of all entries of equal priority
          pos = 0;
          while (pos < held && slot_pri[pos] < pri) pos++;
          for (i = held; i > pos; i--) begin
            slot_pri[i] = slot_pri[i-1];
            slot_tag[i] = slot_tag[i-1];
          end
          slot_pri[pos] = pri;
          slot_tag[pos] = tg;
          held++;
        end
      end else if (held != 0) begin
        r.removed_tag   = slot_tag[0];
        r.removed_valid = 1'b1;
        for (i = 1; i < held; i++) begin
          slot_pri[i-1] = slot_pri[i];
          slot_tag[i-1] = slot_tag[i];
        end
        held--;
      end
      if (held != 0) begin
        r.head_priority = slot_pri[0];
        r.head_tag      = slot_tag[0];
      end else begin
        r.is_empty = 1'b1;
      end
      r.occupancy = held[OCC_W-1:0];
      predicted_q.push_back(r);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      if (predicted_q.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
        return;
      end
      want = predicted_q.pop_front();
      compare_field("removed_tag", want.removed_tag, got.removed_tag);
      compare_field("removed_valid", want.removed_valid, got.removed_valid);
      compare_field("overflow", want.overflow, got.overflow);
      compare_field("head_priority", want.head_priority, got.head_priority);
      compare_field("head_tag", want.head_tag, got.head_tag);
      compare_field("is_empty", want.is_empty, got.is_empty);
      compare_field("occupancy", want.occupancy, got.occupancy);
    endfunction

    function int unsigned outstanding();
      return predicted_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports
  // --------------------------------------------------------------------------
  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             in_valid_i     = 1'b0;
  logic             in_ready_o;
  logic             op_i           = spq_pkg::OP_ENQUEUE;
  logic [PRI_W-1:0] priority_req_i = '0;
  logic [TAG_W-1:0] tag_i          = '0;
  logic             out_valid_o;
  logic             out_ready_i    = 1'b0;
  logic [TAG_W-1:0] removed_tag_o;
  logic             removed_valid_o;
  logic             overflow_o;
  logic [PRI_W-1:0] head_priority_o;
  logic [TAG_W-1:0] head_tag_o;
  logic             is_empty_o;
  logic [OCC_W-1:0] occupancy_o;

  // idling odds in percent, changed per phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  queue_scoreboard sb;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sorted_priority_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .priority_req_i (priority_req_i),
    .tag_i          (tag_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .removed_tag_o  (removed_tag_o),
    .removed_valid_o(removed_valid_o),
    .overflow_o     (overflow_o),
    .head_priority_o(head_priority_o),
    .head_tag_o     (head_tag_o),
    .is_empty_o     (is_empty_o),
    .occupancy_o    (occupancy_o)
  );

  // --------------------------------------------------------------------------
  // result side: random back-pressure and checking of every accepted result
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // values read here are the ones from just before the edge
  always @(posedge clk_i) begin
    queue_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.removed_tag   = removed_tag_o;
      got.removed_valid = removed_valid_o;
      got.overflow      = overflow_o;
      got.head_priority = head_priority_o;
      got.head_tag      = head_tag_o;
      got.is_empty      = is_empty_o;
      got.occupancy     = occupancy_o;
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // present one request, with an optional random gap first, and hold it until
  // the block takes it; valid stays high between back-to-back requests
  task automatic send_request(input logic op, input logic [PRI_W-1:0] pri,
                              input logic [TAG_W-1:0] tg);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    priority_req_i <= pri;
    tag_i          <= tg;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, pri, tg);
  endtask

  // stop sending until every predicted result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // priorities: a narrow band for lots of ties, the two extremes, or anything
  function automatic logic [PRI_W-1:0] pick_priority();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return PRI_W'($urandom_range(7));
    if (roll < 48) return '0;
    if (roll < 56) return '1;
    return PRI_W'($urandom);
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return '1;
    return TAG_W'($urandom);
  endfunction

  // bursts that lean toward filling or draining push the queue to full and
  // to empty over and over; dequeues still carry random (ignored) fields
  task automatic run_random_phase(input int unsigned n_items, input int unsigned send_pct,
                                  input int unsigned recv_pct);
    int unsigned sent;
    int unsigned burst_len;
    int unsigned enq_pct;
    int unsigned k;
    burst_kind_e kind;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      kind      = burst_kind_e'($urandom_range(2));
      burst_len = $urandom_range(8, 40);
      case (kind)
        BURST_FILL:  enq_pct = 85;
        BURST_DRAIN: enq_pct = 15;
        default:     enq_pct = 50;
      endcase
      for (k = 0; k < burst_len && sent < n_items; k++) begin
        send_request(($urandom_range(99) < enq_pct) ? spq_pkg::OP_ENQUEUE
                                                     : spq_pkg::OP_DEQUEUE,
                     pick_priority(), pick_tag());
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty dequeue, extremes, ties at the head and in the middle
    send_request(spq_pkg::OP_DEQUEUE, '1, '1);
    send_request(spq_pkg::OP_ENQUEUE, '1, '1);
    send_request(spq_pkg::OP_ENQUEUE, '0, '0);
    send_request(spq_pkg::OP_ENQUEUE, 16'h8000, 32'h0000_0001);
    send_request(spq_pkg::OP_ENQUEUE, 16'h8000, 32'h0000_0002);
    send_request(spq_pkg::OP_ENQUEUE, 16'h8000, 32'h0000_0003);
    send_request(spq_pkg::OP_ENQUEUE, '0, 32'h5555_5555);
    send_request(spq_pkg::OP_ENQUEUE, 16'h7fff, 32'haaaa_aaaa);
    repeat (8) send_request(spq_pkg::OP_DEQUEUE, PRI_W'($urandom), TAG_W'($urandom));
    drain_results();

    // receiver idles more, then sender idles more, then full speed both ways
    run_random_phase(580, 20, 52);
    drain_results();
    run_random_phase(580, 52, 20);
    drain_results();
    run_random_phase(580, 0, 0);
    drain_results();

    // a few more cycles to catch any result the block should not produce
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("PASS sorted_priority_queue");
    end else begin
      $display("FAIL sorted_priority_queue");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAIL sorted_priority_queue");
    $finish;
  end

endmodule

// File: files.f
design/spq_pkg.sv
design/spq_ctrl.sv
design/spq_datapath.sv
design/sorted_priority_queue.sv
design/spq_checker.sv
test/tb_sorted_priority_queue.sv
